[hw/rtl/chained_hash_table_defines.svh]
// ----------------------------------------------------------------------------
// chained_hash_table_defines
// Assertion macros used by the checker file of the hash table block.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Types, constants and helper functions of the chained hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

	// Table geometry
	localparam int NUM_BUCKETS = 7;
	localparam int CHAIN_DEPTH = 8;

	// Field widths
	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int ST_W   = 2;
	localparam int BKT_W  = 3;
	localparam int SLOT_W = 3;
	localparam int FILL_W = 4;
	localparam int ADDR_W = $clog2(NUM_BUCKETS * CHAIN_DEPTH);

	// Remainder is built one key byte per cycle, MSB first
	localparam int DIGIT_W    = 8;
	localparam int HASH_STEPS = KEY_W / DIGIT_W;
	localparam int STEP_W     = $clog2(HASH_STEPS);

	// Opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] key;
	} cht_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [BKT_W-1:0]  bucket;
		logic [SLOT_W-1:0] position;
		logic [FILL_W-1:0] fill;
	} cht_rsp_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic            load;
		logic            hash_step;
		logic            idx_clr;
		logic            idx_inc;
		logic            rd;
		logic            sh_rd;
		logic            sh_wr;
		logic            ins_wr;
		logic            cnt_dec;
		logic            take_idx;
		logic            st_we;
		logic [ST_W-1:0] st;
	} cht_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            hash_last;
		logic            full;
		logic            idx_end;
		logic            sh_end;
		logic            match;
	} cht_sts_t;

	// Fold one key byte into a running remainder mod NUM_BUCKETS, bit by bit
	function automatic logic [BKT_W-1:0] cht_mod_step(input logic [BKT_W-1:0] r,
			input logic [DIGIT_W-1:0] d);
		logic [BKT_W:0]   t;
		logic [BKT_W-1:0] rr;
		rr = r;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {rr, d[i]};
			if (t >= (BKT_W + 1)'(NUM_BUCKETS)) begin
				t = t - (BKT_W + 1)'(NUM_BUCKETS);
			end
			rr = t[BKT_W-1:0];
		end
		return rr;
	endfunction

	// Flat entry address of (bucket, slot)
	function automatic logic [ADDR_W-1:0] cht_addr(input logic [BKT_W-1:0] b,
			input logic [SLOT_W-1:0] s);
		return ADDR_W'(b) * ADDR_W'(CHAIN_DEPTH) + ADDR_W'(s);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/cht_dp.sv]
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: key remainder unit, bucket counts, chain entry memory and the
// result registers. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_dp
	import cht_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cht_req_t req,
	input  wire cht_cmd_t cmd,
	output cht_sts_t      sts,
	output cht_rsp_t      rsp
);

	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [STEP_W-1:0] step_q;
	logic [FILL_W-1:0] idx_q;
	logic [ST_W-1:0]   status_q;
	logic [SLOT_W-1:0] pos_q;
	logic [FILL_W-1:0] cnt_q [NUM_BUCKETS];
	logic [KEY_W-1:0]  mem [NUM_BUCKETS * CHAIN_DEPTH];
	logic [KEY_W-1:0]  rdata_q;

	logic [FILL_W-1:0]  count;
	logic [FILL_W-1:0]  idx_nxt;
	logic [DIGIT_W-1:0] digit;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [KEY_W-1:0]   mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;

	assign count   = cnt_q[bkt_q];
	assign idx_nxt = idx_q + FILL_W'(1);
	assign digit   = key_q[(HASH_STEPS - 1 - int'(step_q)) * DIGIT_W +: DIGIT_W];

	// Request registers and remainder unit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			bkt_q <= '0;
		end else if (cmd.hash_step) begin
			bkt_q <= cht_mod_step(bkt_q, digit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.hash_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Chain slot pointer
	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_nxt;
		end
	end

	// Bucket fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.ins_wr) begin
			cnt_q[bkt_q] <= count + FILL_W'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q[bkt_q] <= count - FILL_W'(1);
		end
	end

	// Result status and position
	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			status_q <= cmd.st;
		end
		if (cmd.load) begin
			pos_q <= '0;
		end else if (cmd.ins_wr) begin
			pos_q <= count[SLOT_W-1:0];
		end else if (cmd.take_idx) begin
			pos_q <= idx_q[SLOT_W-1:0];
		end
	end

	// Entry memory ports: append or shift-down on write, probe or shift on read
	always_comb begin
		mem_we    = cmd.ins_wr || cmd.sh_wr;
		mem_waddr = cmd.ins_wr ? cht_addr(bkt_q, count[SLOT_W-1:0])
		                       : cht_addr(bkt_q, idx_q[SLOT_W-1:0]);
		mem_wdata = cmd.ins_wr ? key_q : rdata_q;
		mem_re    = cmd.rd || cmd.sh_rd;
		mem_raddr = cmd.sh_rd ? cht_addr(bkt_q, idx_nxt[SLOT_W-1:0])
		                      : cht_addr(bkt_q, idx_q[SLOT_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Status back to the controller
	always_comb begin
		sts.op        = op_q;
		sts.hash_last = (step_q == STEP_W'(HASH_STEPS - 1));
		sts.full      = (count >= FILL_W'(CHAIN_DEPTH));
		sts.idx_end   = (idx_q >= count);
		sts.sh_end    = (idx_nxt >= count);
		sts.match     = (rdata_q == key_q);
	end

	assign rsp.status   = status_q;
	assign rsp.bucket   = bkt_q;
	assign rsp.position = pos_q;
	assign rsp.fill     = count;

endmodule

`default_nettype wire

[hw/rtl/cht_ctrl.sv]
// ----------------------------------------------------------------------------
// cht_ctrl
// Controller: sequences hashing, chain probing, insert and delete shifting,
// and raises the one-cycle done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl
	import cht_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire cht_sts_t sts,
	output cht_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_HASH  = 8'b0000_0010,
		S_OPSEL = 8'b0000_0100,
		S_RD    = 8'b0000_1000,
		S_CMP   = 8'b0001_0000,
		S_SHR   = 8'b0010_0000,
		S_SHW   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					state_d = S_OPSEL;
				end
			end
			S_OPSEL: begin
				priority if (sts.op == OP_INSERT) begin
					cmd.st_we = 1'b1;
					if (sts.full) begin
						cmd.st = ST_FULL;
					end else begin
						cmd.st     = ST_OK;
						cmd.ins_wr = 1'b1;
					end
					state_d = S_DONE;
				end else if (sts.op == OP_SEARCH || sts.op == OP_DELETE) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RD;
				end else begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_NOT_FOUND;
					state_d   = S_DONE;
				end
			end
			S_RD: begin
				if (sts.idx_end) begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_NOT_FOUND;
					state_d   = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.st_we    = 1'b1;
					cmd.st       = ST_OK;
					cmd.take_idx = 1'b1;
					state_d      = (sts.op == OP_DELETE) ? S_SHR : S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_SHR: begin
				if (sts.sh_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SHW;
				end
			end
			S_SHW: begin
				cmd.sh_wr   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_SHR;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/chained_hash_table.sv]
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining: insert, search and delete of 32-bit keys
// in NUM_BUCKETS buckets of up to CHAIN_DEPTH entries each.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on rsp for the single cycle in which done is high, and the
// receiver cannot stall it, so it must capture rsp whenever done is seen.
// The bucket (key mod NUM_BUCKETS) is built one key byte per cycle. Insert
// then appends the key at the end of its chain, or reports full; search and
// delete probe the chain slot by slot through the entry memory, a read then
// a compare per slot, and delete shifts each later entry down, a read then
// a write per entry. A new request can be taken in the cycle after done.
// The fill counts are cleared by reset; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table
	import cht_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire cht_req_t req,
	output logic          busy,
	output logic          done,
	output cht_rsp_t      rsp
);

	cht_cmd_t cmd;
	cht_sts_t sts;

	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

[hw/rtl/cht_checker.sv]
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_table_defines.svh"

module cht_checker
	import cht_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire cht_rsp_t rsp
);

	// An accepted request keeps the block busy until its result
	`CHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

	// A result is only shown while its request is still in flight
	`CHT_ASSERT_NOW(a_done_busy, done, busy, "done strobe while idle")

	// One result per request: the done strobe is never held high
	`CHT_ASSERT_NEXT(a_done_single, done, !done, "done strobe held two cycles")

	// Result fields stay in range
	`CHT_ASSERT_NOW(a_rsp_range, done,
		rsp.bucket < BKT_W'(NUM_BUCKETS) && rsp.fill <= FILL_W'(CHAIN_DEPTH)
		&& rsp.status != 2'd3, "result field out of range")

	// A full bucket reports a full chain and slot zero
	`CHT_ASSERT_NOW(a_full_rsp, done && rsp.status == ST_FULL,
		rsp.fill == FILL_W'(CHAIN_DEPTH) && rsp.position == '0, "bad full result")

endmodule

bind chained_hash_table cht_checker u_cht_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
